>>> src/adpp_pkg.sv
// ----------------------------------------------------------------------------
// adpp_pkg
// shared types and constants of the dot product argmax block
// ----------------------------------------------------------------------------
package adpp_pkg;

    localparam int COORD_W   = 16;
    localparam int NUM_LANES = 6;
    localparam int NUM_PAIRS = NUM_LANES / 2;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 3;
    localparam int SCORE_W   = 33;
    localparam int INDEX_W   = 16;
    localparam int DIMS_W    = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        REG_DIMS,
        REG_DIR_0,
        REG_DIR_1,
        REG_DIR_2,
        REG_DIR_3,
        REG_DIR_4,
        REG_DIR_5
    } t_reg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef struct packed {
        t_coord coord_0;
        t_coord coord_1;
        t_coord coord_2;
        t_coord coord_3;
        t_coord coord_4;
        t_coord coord_5;
        logic   last_point;
    } t_in_beat;

    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        t_coord             best_c0;
        t_coord             best_c1;
        t_coord             best_c2;
        t_coord             best_c3;
        t_coord             best_c4;
        t_coord             best_c5;
        logic [SCORE_W-1:0] best_score;
    } t_out_beat;

    typedef struct packed {
        logic pair_en;
        logic total_en;
    } t_sum_en;

endpackage

>>> src/adpp_lane.sv
// ----------------------------------------------------------------------------
// adpp_lane
// one multiply lane: coordinate times direction component, registered
// ----------------------------------------------------------------------------
module adpp_lane import adpp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  logic   i_use,
    input  t_coord i_coord,
    input  t_coord i_dir,
    output t_prod  o_prod
);

    t_prod r_prod;
    t_prod n_prod;

    // unused lanes contribute zero; operands widened first for a full product
    always_comb begin
        n_prod = i_use ? t_prod'(i_coord) * t_prod'(i_dir) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> src/adpp_sum.sv
// ----------------------------------------------------------------------------
// adpp_sum
// registered two-level adder tree over the lane products
// ----------------------------------------------------------------------------
module adpp_sum import adpp_pkg::*; (
    input  logic    i_clk,
    input  t_sum_en i_en,
    input  t_prod   i_prod [NUM_LANES],
    output t_sum    o_total
);

    logic signed [PAIR_W-1:0] r_pair [NUM_PAIRS];
    logic signed [PAIR_W-1:0] n_pair [NUM_PAIRS];
    t_sum                     r_total;
    t_sum                     n_total;

    always_comb begin
        for (int k = 0; k < NUM_PAIRS; k++) begin
            n_pair[k] = PAIR_W'(i_prod[2*k]) + PAIR_W'(i_prod[2*k+1]);
        end
    end

    always_comb begin
        n_total = '0;
        for (int k = 0; k < NUM_PAIRS; k++) begin
            n_total = n_total + SUM_W'(r_pair[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.pair_en) begin
            r_pair <= n_pair;
        end
        if (i_en.total_en) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

>>> src/adpp_best.sv
// ----------------------------------------------------------------------------
// adpp_best
// winner tracker: compares each score with the best so far, emits on last
// ----------------------------------------------------------------------------
module adpp_best import adpp_pkg::*; #(
    parameter int MAX_POINTS = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_sum      i_score,
    input  t_in_beat  i_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int               CNT_W   = $clog2(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_POINTS - 1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_win_idx;
    logic [SCORE_W-1:0] r_win_score;
    t_in_beat           r_win_pt;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic [CNT_W-1:0]   n_win_idx;
    logic [SCORE_W-1:0] n_win_score;
    t_in_beat           n_win_pt;
    logic [INDEX_W-1:0] idx_ext;
    t_out_beat          n_out;
    logic               pos;
    logic               gt;
    logic               take;

    // a last beat needs a free output slot
    assign o_ready = !(i_valid && i_beat.last_point && r_out_valid && !i_out_ready);
    assign take    = i_valid && o_ready;

    assign pos = !i_score[SUM_W-1] && (i_score != '0);
    assign gt  = i_score[SUM_W-2:0] > {{(SUM_W-1-SCORE_W){1'b0}}, r_win_score};

    always_comb begin
        n_win_idx   = r_win_idx;
        n_win_score = r_win_score;
        n_win_pt    = r_win_pt;
        if (r_count == '0) begin
            n_win_idx   = '0;
            n_win_score = pos ? i_score[SCORE_W-1:0] : '0;
            n_win_pt    = i_beat;
        end else if (pos && gt) begin
            n_win_idx   = r_count;
            n_win_score = i_score[SCORE_W-1:0];
            n_win_pt    = i_beat;
        end
    end

    always_comb begin
        idx_ext            = '0;
        idx_ext[CNT_W-1:0] = n_win_idx;
        n_out.best_index   = idx_ext;
        n_out.best_c0      = n_win_pt.coord_0;
        n_out.best_c1      = n_win_pt.coord_1;
        n_out.best_c2      = n_win_pt.coord_2;
        n_out.best_c3      = n_win_pt.coord_3;
        n_out.best_c4      = n_win_pt.coord_4;
        n_out.best_c5      = n_win_pt.coord_5;
        n_out.best_score   = n_win_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_win_idx   <= '0;
            r_win_score <= '0;
            r_win_pt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_beat.last_point) begin
                r_count     <= '0;
                r_win_idx   <= '0;
                r_win_score <= '0;
                r_win_pt    <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (take) begin
                    r_win_idx   <= n_win_idx;
                    r_win_score <= n_win_score;
                    r_win_pt    <= n_win_pt;
                    if (r_count != CNT_TOP) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_beat.last_point) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/argmax_dot_product_point.sv
// ----------------------------------------------------------------------------
// argmax_dot_product_point
// Streaming argmax of a dot product over a set of points. Each input beat is
// one point of six Q1.15 coordinates; the block scores it against the
// configured direction using the first dims_in_use coordinates (values above
// six count as six), and keeps the index, coordinates and exact UQ3.30 score
// of the best point. The best score starts at zero and only a strictly larger
// score replaces it, so point 0 wins when no score is positive. The beat
// flagged last_point produces one output beat with the winner and clears the
// tracker for the next set; the index saturates at MAX_POINTS-1. A point is
// accepted every cycle unless stalled: six multiply lanes, a two-level
// registered adder tree and the compare/update loop of the winner tracker
// give one point per cycle; each point passes the product, pair-sum and total
// registers to the tracker. Input stalls only when a last point reaches the
// tracker while the previous result still waits in the output register.
// Configuration sits on an APB port: dims_in_use at 0x00, dir_0..dir_5 at
// 0x04..0x18; the user writes them only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module argmax_dot_product_point import adpp_pkg::*; #(
    parameter int MAX_POINTS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input point channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [DIMS_W-1:0] r_dims;
    t_coord            r_dir [NUM_LANES];
    logic [DIMS_W-1:0] dims_eff;
    logic              cfg_wr;

    // pipeline control: stage 1 products, stage 2 pair sums, stage 3 total
    logic     r_v1, r_v2, r_v3;
    t_in_beat r_side1, r_side2, r_side3;
    logic     ld1, ld2, ld3;
    logic     in_acc;
    logic     best_ready;

    t_coord   in_coord [NUM_LANES];
    logic     lane_use [NUM_LANES];
    t_prod    lane_prod [NUM_LANES];
    t_sum     total;
    t_sum_en  sum_en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(NUM_LANES);
            for (int k = 0; k < NUM_LANES; k++) begin
                r_dir[k] <= '0;
            end
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[ADDR_W-1:2]))
                REG_DIMS:  r_dims   <= pwdata[DIMS_W-1:0];
                REG_DIR_0: r_dir[0] <= pwdata[COORD_W-1:0];
                REG_DIR_1: r_dir[1] <= pwdata[COORD_W-1:0];
                REG_DIR_2: r_dir[2] <= pwdata[COORD_W-1:0];
                REG_DIR_3: r_dir[3] <= pwdata[COORD_W-1:0];
                REG_DIR_4: r_dir[4] <= pwdata[COORD_W-1:0];
                REG_DIR_5: r_dir[5] <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back, zero extended
    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_DIMS:  prdata[DIMS_W-1:0]  = r_dims;
            REG_DIR_0: prdata[COORD_W-1:0] = r_dir[0];
            REG_DIR_1: prdata[COORD_W-1:0] = r_dir[1];
            REG_DIR_2: prdata[COORD_W-1:0] = r_dir[2];
            REG_DIR_3: prdata[COORD_W-1:0] = r_dir[3];
            REG_DIR_4: prdata[COORD_W-1:0] = r_dir[4];
            REG_DIR_5: prdata[COORD_W-1:0] = r_dir[5];
            default:   prdata = '0;
        endcase
    end

    // dims above the lane count clamp to all lanes
    assign dims_eff = (r_dims > DIMS_W'(NUM_LANES)) ? DIMS_W'(NUM_LANES) : r_dims;

    // ---------------- pipeline handshake ----------------
    // each stage loads when empty or when the stage after it moves on
    assign ld3        = !r_v3 || best_ready;
    assign ld2        = !r_v2 || ld3;
    assign ld1        = !r_v1 || ld2;
    assign o_in_ready = ld1;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= in_acc;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // point and last flag ride alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_side1 <= i_in_data;
        end
        if (ld2) begin
            r_side2 <= r_side1;
        end
        if (ld3) begin
            r_side3 <= r_side2;
        end
    end

    // ---------------- multiply lanes ----------------
    assign in_coord[0] = i_in_data.coord_0;
    assign in_coord[1] = i_in_data.coord_1;
    assign in_coord[2] = i_in_data.coord_2;
    assign in_coord[3] = i_in_data.coord_3;
    assign in_coord[4] = i_in_data.coord_4;
    assign in_coord[5] = i_in_data.coord_5;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_use[g] = DIMS_W'(g) < dims_eff;

        adpp_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (ld1),
            .i_use   (lane_use[g]),
            .i_coord (in_coord[g]),
            .i_dir   (r_dir[g]),
            .o_prod  (lane_prod[g])
        );
    end

    // ---------------- adder tree ----------------
    assign sum_en.pair_en  = ld2;
    assign sum_en.total_en = ld3;

    adpp_sum u_sum (
        .i_clk   (i_clk),
        .i_en    (sum_en),
        .i_prod  (lane_prod),
        .o_total (total)
    );

    // ---------------- winner tracker and output register ----------------
    adpp_best #(
        .MAX_POINTS (MAX_POINTS)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v3),
        .o_ready     (best_ready),
        .i_score     (total),
        .i_beat      (r_side3),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

    // ---------------- assertions ----------------
    // input stalls only behind a blocked result beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked output beat");

    // a stall means every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a bubble in the pipeline");

    // a result appears only after a last point left the tree
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v3 && r_side3.last_point))
        else $error("result beat without a last point");

endmodule
